/* rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: function codes,
// control characters, field widths and the command and result items.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    // Field widths
    localparam int FUNC_W = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 13;
    localparam int POS_W  = 13;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // Character codes and reset attribute
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

    typedef logic [CELL_W-1:0] t_cell;

    // Command item as held by the engine
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } t_cmd;

    // Result item
    typedef struct packed {
        logic [POS_W-1:0] cursor_pos;
        t_cell            cell_data;
        logic             scrolled;
    } t_result;

endpackage

`default_nettype wire

/* rtl/tcw_if.sv */
// ----------------------------------------------------------------------------
// tcw_if
// Valid/ready channels of the text console writer: command in, result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_cmd_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;

    modport source (output valid, output func, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input func, input char_code, input cell_index,
                    output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] cursor_pos;
    t_cell            cell_data;
    logic             scrolled;

    modport source (output valid, output cursor_pos, output cell_data, output scrolled,
                    input ready);
    modport sink   (input valid, input cursor_pos, input cell_data, input scrolled,
                    output ready);
endinterface

`default_nettype wire

/* rtl/tcw_ram.sv */
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 4800,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/tcw_engine.sv */
// ----------------------------------------------------------------------------
// tcw_engine
// Command sequencer: cursor registers, put/read handling and the sweeps
// over the screen store for reset fill, clear and scroll.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_engine import tcw_pkg::*; #(
    parameter  int COLUMNS = 80,
    parameter  int ROWS    = 60,
    localparam int CELLS   = COLUMNS * ROWS,
    localparam int AW      = $clog2(CELLS)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // command side
    input  wire logic              i_cmd_valid,
    output logic                   o_cmd_ready,
    input  wire t_cmd              i_cmd,
    input  wire logic [ATTR_W-1:0] i_attr,
    // result side
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output t_result                o_res,
    // screen store
    output logic                   o_ram_we,
    output logic [AW-1:0]          o_ram_waddr,
    output t_cell                  o_ram_wdata,
    output logic                   o_ram_re,
    output logic [AW-1:0]          o_ram_raddr,
    input  wire t_cell             i_ram_rdata
);

    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_EXEC   = 7'b0000100,
        S_READ   = 7'b0001000,
        S_SCROLL = 7'b0010000,
        S_CLEAR  = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state         r_state, n_state;
    t_cmd           r_cmd;
    logic [CW-1:0]  r_col, n_col;
    logic [RW-1:0]  r_row, n_row;
    logic           r_scrolled, n_scrolled;
    logic [AW-1:0]  r_cnt, n_cnt;

    logic [AW-1:0]  cur_lin;
    logic [AW:0]    scroll_rd;
    logic           cnt_last;
    logic           scroll_src;
    logic           row_inc;
    logic           finish;
    t_cell          blank;
    t_cell          data;

    // Cursor address, sweep bookkeeping
    assign cur_lin    = AW'(32'(r_row) * 32'(COLUMNS) + 32'(r_col));
    assign scroll_rd  = (AW+1)'(r_cnt) + (AW+1)'(COLUMNS + 1);
    assign cnt_last   = (r_cnt == AW'(CELLS - 1));
    assign scroll_src = (r_cnt < AW'(CELLS - COLUMNS));
    assign blank      = {i_attr, CH_SPACE};

    // Next-state and store access
    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_scrolled  = r_scrolled;
        n_cnt       = r_cnt;
        o_ram_we    = 1'b0;
        o_ram_waddr = cur_lin;
        o_ram_wdata = blank;
        o_ram_re    = 1'b0;
        o_ram_raddr = AW'(COLUMNS);
        o_res_valid = 1'b0;
        data        = '0;
        row_inc     = 1'b0;
        finish      = 1'b0;

        unique case (r_state)
            S_INIT: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_cnt;
                o_ram_wdata = {ATTR_RESET, CH_SPACE};
                n_cnt       = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_scrolled = 1'b0;
                if (i_cmd_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd.func)
                    FUNC_PUT: begin
                        if (r_cmd.char_code == CH_NEWLINE) begin
                            n_col   = '0;
                            row_inc = 1'b1;
                        end else if (r_cmd.char_code == CH_BACKSPACE) begin
                            if (r_col != '0) begin
                                n_col       = r_col - 1'b1;
                                o_ram_we    = 1'b1;
                                o_ram_waddr = cur_lin - 1'b1;
                            end
                        end else begin
                            o_ram_we    = 1'b1;
                            o_ram_wdata = {i_attr, r_cmd.char_code};
                            if (r_col == CW'(COLUMNS - 1)) begin
                                n_col   = '0;
                                row_inc = 1'b1;
                            end else begin
                                n_col = r_col + 1'b1;
                            end
                        end
                        // past the last row: prime the first copy read
                        if (row_inc && r_row == RW'(ROWS - 1)) begin
                            n_scrolled  = 1'b1;
                            o_ram_re    = 1'b1;
                            o_ram_raddr = AW'(COLUMNS);
                            n_cnt       = '0;
                            n_state     = S_SCROLL;
                        end else begin
                            if (row_inc) begin
                                n_row = r_row + 1'b1;
                            end
                            finish = 1'b1;
                        end
                    end
                    FUNC_CLEAR: begin
                        n_col   = '0;
                        n_row   = '0;
                        n_cnt   = '0;
                        n_state = S_CLEAR;
                    end
                    FUNC_READ: begin
                        if (32'(r_cmd.cell_index) < CELLS) begin
                            o_ram_re    = 1'b1;
                            o_ram_raddr = AW'(r_cmd.cell_index);
                            n_state     = S_READ;
                        end else begin
                            finish = 1'b1;
                        end
                    end
                    default: begin
                        finish = 1'b1;
                    end
                endcase
            end
            S_READ: begin
                o_res_valid = 1'b1;
                data        = i_ram_rdata;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_SCROLL: begin
                // copy row below into this cell, blank the bottom row
                o_ram_we    = 1'b1;
                o_ram_waddr = r_cnt;
                o_ram_wdata = scroll_src ? i_ram_rdata : blank;
                if (scroll_rd < (AW+1)'(CELLS)) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = scroll_rd[AW-1:0];
                end
                n_cnt = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_cnt  = '0;
                    finish = 1'b1;
                end
            end
            S_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_cnt;
                n_cnt       = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_cnt  = '0;
                    finish = 1'b1;
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // hand the result over, or park it until the output side frees
        if (finish) begin
            o_res_valid = 1'b1;
            n_state     = i_res_ready ? S_IDLE : S_DONE;
        end
    end

    assign o_cmd_ready      = (r_state == S_IDLE);
    assign o_res.cursor_pos = POS_W'(32'(n_row) * 32'(COLUMNS) + 32'(n_col));
    assign o_res.cell_data  = data;
    assign o_res.scrolled   = n_scrolled;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_col      <= '0;
            r_row      <= '0;
            r_scrolled <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_row      <= n_row;
            r_scrolled <= n_scrolled;
            r_cnt      <= n_cnt;
        end
    end

    // Command capture
    always_ff @(posedge i_clk) begin
        if (o_cmd_ready && i_cmd_valid) begin
            r_cmd <= i_cmd;
        end
    end

`ifndef SYNTHESIS
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= RW'(ROWS - 1)) && (r_col <= CW'(COLUMNS - 1)))
        else $error("cursor outside the screen");

    a_sweep_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCROLL || r_state == S_CLEAR) && !cnt_last)
        |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("sweep counter skipped a cell");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> o_res_valid)
        else $error("result dropped while output stalled");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.scrolled) |-> (r_row == RW'(ROWS - 1)))
        else $error("scrolled result not on the last row");
`endif

endmodule

`default_nettype wire

/* rtl/text_console_writer_top.sv */
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text-mode console engine over a screen store of attribute/character cells.
//
//   channel   | dir | handshake     | payload
//   ----------+-----+---------------+-----------------------------------------
//   i_cmd     | in  | valid/ready   | func, char_code, cell_index
//   o_rsp     | out | valid/ready   | cursor_pos, cell_data, scrolled
//   i_cfg_*   | in  | write enable  | text attribute byte
//
// Put character: accept, then one store write and cursor update.
// Read: the data comes from the registered read port of the screen store;
// an index past the store ends the command without a store read.
// Clear and scroll: one store cell per cycle.
// After reset a fill pass blanks every store cell; no item is accepted
// meanwhile. A stalled output holds one result in its register while the
// engine accepts and works on the next item.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_top import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 60
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    tcw_cmd_if.sink                i_cmd,
    tcw_rsp_if.source              o_rsp,
    input  wire logic              i_cfg_we,
    input  wire logic [ATTR_W-1:0] i_cfg_wdata
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    logic [ATTR_W-1:0] r_attr;
    logic              r_out_valid;
    t_result           r_out;

    t_cmd              cmd;
    logic              cmd_ready;
    logic              res_valid;
    logic              res_ready;
    t_result           res;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    t_cell             ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    t_cell             ram_rdata;

    // Attribute register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_wdata;
        end
    end

    assign cmd.func       = i_cmd.func;
    assign cmd.char_code  = i_cmd.char_code;
    assign cmd.cell_index = i_cmd.cell_index;
    assign i_cmd.ready    = cmd_ready;

    tcw_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .i_attr      (r_attr),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Output register
    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.cursor_pos = r_out.cursor_pos;
    assign o_rsp.cell_data  = r_out.cell_data;
    assign o_rsp.scrolled   = r_out.scrolled;

endmodule

`default_nettype wire
